FILE: rtl/fng_pkg.sv
// shared types and constants of the face normal generator
`default_nettype none
package fng_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CROSS,
    ST_NORM,
    ST_SQUARE,
    ST_SQRT_GO,
    ST_SQRT,
    ST_DLOAD,
    ST_DIV,
    ST_EMIT
  } state_e;

  localparam logic [2:0]  TRI_SIZE   = 3'd3;
  localparam logic [2:0]  QUAD_SIZE  = 3'd4;
  localparam logic [1:0]  HELD_DEPTH = 2'd3;
  localparam int          NORM_BITS  = 30;
  localparam logic [15:0] ONE_Q14    = 16'd16384;

endpackage
`default_nettype wire

FILE: rtl/fng_vertex_if.sv
// vertex channel: valid/ready with one vertex per transaction
`default_nettype none
interface fng_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic               end_of_buffer;

  modport source (output valid, vertex_x, vertex_y, vertex_z, end_of_buffer, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, end_of_buffer, output ready);
endinterface
`default_nettype wire

FILE: rtl/fng_normal_if.sv
// normal channel: valid/ready with one Q2.14 normal per transaction
`default_nettype none
interface fng_normal_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               degenerate;
  logic               last_of_run;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, last_of_run,
                  input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, last_of_run,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/fng_isqrt.sv
// iterative integer square root, one result bit per cycle
`default_nettype none
module fng_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [61:0] radicand_i,
  output logic        done_o,
  output logic [30:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [61:0] v_q, v_d;
  logic [61:0] res_q, res_d;
  logic [61:0] bit_q, bit_d;
  logic [61:0] trial;

  assign trial = res_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      v_d    = radicand_i;
      res_d  = '0;
      bit_d  = 62'd1 << 60;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[30:0];

endmodule
`default_nettype wire

FILE: rtl/face_normal_generator_top.sv
// top level of the flat face normal generator
//
//  channel     dir   handshake      payload
//  vertex_i    in    valid/ready    vertex_x/y/z (Q16.16), end_of_buffer
//  normal_o    out   valid/ready    normal_x/y/z (Q2.14), degenerate, last_of_run
//  cfg         in    cfg_we_i       cfg_wdata_i = primitive_mode
//
// a vertex that neither closes nor flushes a group is held and advances the group position
// a closing vertex passes a diff step, the cross product on the shared 33x33
// multiplier, the normalize loop that shifts all magnitudes right, the squares,
// the root unit and the divider before its first normal; a degenerate face
// goes to its normals straight from the normalize loop,
// then normals are handed out one per cycle; stalls on normal_o hold the sequencer
// reset clears mode and group position; held vertices are written before use
`default_nettype none
module face_normal_generator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  fng_vertex_if.sink          vertex_i,
  fng_normal_if.source        normal_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  // multiplier operand indexes into the edge vectors: ax ay az bx by bz
  localparam logic [2:0] CROSS_A [6] = '{3'd2, 3'd1, 3'd0, 3'd2, 3'd1, 3'd0};
  localparam logic [2:0] CROSS_B [6] = '{3'd4, 3'd5, 3'd5, 3'd3, 3'd3, 3'd4};

  fng_pkg::state_e state_q, state_d;

  // control state
  logic        mode_q, mode_d;
  logic [1:0]  pos_q, pos_d;
  logic [2:0]  step_q, step_d;
  logic [2:0]  left_q, left_d;
  logic [1:0]  comp_q, comp_d;
  logic [3:0]  cnt_q, cnt_d;

  // datapath
  logic signed [31:0] held_x_q [3];
  logic signed [31:0] held_y_q [3];
  logic signed [31:0] held_z_q [3];
  logic               held_we;
  logic signed [32:0] diff_q [6], diff_d [6];
  logic signed [65:0] prod_q, prod_d;
  logic signed [65:0] first_q, first_d;
  logic [65:0]        mag_q [3], mag_d [3];
  logic               neg_q [3], neg_d [3];
  logic [61:0]        sum_q, sum_d;
  logic [30:0]        len_q, len_d;
  logic [47:0]        rem_q, rem_d;
  logic [15:0]        quo_q, quo_d;
  logic signed [15:0] nrm_q [3], nrm_d [3];
  logic               degen_q, degen_d;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_prod;
  assign mul_prod = mul_a * mul_b;

  logic [2:0]   pos_new, gsize, kstep;
  logic [66:0]  cdiff, cmag;
  logic [65:0]  orv;
  logic [47:0]  trial;
  logic         hit;
  logic [15:0]  quo_set, qclamp;

  logic         sqrt_start, sqrt_done;
  logic [30:0]  sqrt_root;

  fng_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sum_q),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  assign vertex_i.ready       = (state_q == fng_pkg::ST_IDLE);
  assign normal_o.valid       = (state_q == fng_pkg::ST_EMIT);
  assign normal_o.normal_x    = nrm_q[0];
  assign normal_o.normal_y    = nrm_q[1];
  assign normal_o.normal_z    = nrm_q[2];
  assign normal_o.degenerate  = degen_q;
  assign normal_o.last_of_run = (left_q == 3'd1);

  assign pos_new = {1'b0, pos_q} + 3'd1;
  assign gsize   = mode_q ? fng_pkg::QUAD_SIZE : fng_pkg::TRI_SIZE;
  assign kstep   = step_q - 3'd1;
  assign held_we = vertex_i.valid && vertex_i.ready && (pos_q < fng_pkg::HELD_DEPTH);

  // cross term: first product minus second, as sign and magnitude
  assign cdiff = {first_q[65], first_q} - {prod_q[65], prod_q};
  assign cmag  = cdiff[66] ? (67'd0 - cdiff) : cdiff;
  assign orv   = mag_q[0] | mag_q[1] | mag_q[2];

  // restoring division step against 2*len shifted into place
  assign trial   = 48'({len_q, 1'b0}) << cnt_q;
  assign hit     = (rem_q >= trial);
  assign quo_set = quo_q | (16'(hit) << cnt_q);
  assign qclamp  = (quo_set > fng_pkg::ONE_Q14) ? fng_pkg::ONE_Q14 : quo_set;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    pos_d      = pos_q;
    step_d     = step_q;
    left_d     = left_q;
    comp_d     = comp_q;
    cnt_d      = cnt_q;
    diff_d     = diff_q;
    prod_d     = prod_q;
    first_d    = first_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    sum_d      = sum_q;
    len_d      = len_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    nrm_d      = nrm_q;
    degen_d    = degen_q;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;

    case (state_q)
      fng_pkg::ST_IDLE: begin
        if (vertex_i.valid) begin
          if (pos_new >= gsize) begin
            // group complete
            pos_d   = '0;
            left_d  = gsize;
            degen_d = 1'b0;
            state_d = fng_pkg::ST_DIFF;
          end else if (vertex_i.end_of_buffer) begin
            // partial group flush: zero normals flagged degenerate
            pos_d    = '0;
            left_d   = pos_new;
            nrm_d[0] = '0;
            nrm_d[1] = '0;
            nrm_d[2] = '0;
            degen_d  = 1'b1;
            state_d  = fng_pkg::ST_EMIT;
          end else begin
            pos_d = pos_new[1:0];
          end
        end
      end
      fng_pkg::ST_DIFF: begin
        // a = v1 - v0, b = v1 - v2
        diff_d[0] = {held_x_q[1][31], held_x_q[1]} - {held_x_q[0][31], held_x_q[0]};
        diff_d[1] = {held_y_q[1][31], held_y_q[1]} - {held_y_q[0][31], held_y_q[0]};
        diff_d[2] = {held_z_q[1][31], held_z_q[1]} - {held_z_q[0][31], held_z_q[0]};
        diff_d[3] = {held_x_q[1][31], held_x_q[1]} - {held_x_q[2][31], held_x_q[2]};
        diff_d[4] = {held_y_q[1][31], held_y_q[1]} - {held_y_q[2][31], held_y_q[2]};
        diff_d[5] = {held_z_q[1][31], held_z_q[1]} - {held_z_q[2][31], held_z_q[2]};
        step_d    = '0;
        state_d   = fng_pkg::ST_CROSS;
      end
      fng_pkg::ST_CROSS: begin
        // one product per cycle, each pair combined in the cycle after its second product
        if (step_q < 3'd6) begin
          mul_a  = diff_q[CROSS_A[step_q]];
          mul_b  = diff_q[CROSS_B[step_q]];
          prod_d = mul_prod;
        end
        if (step_q != 3'd0) begin
          if (!kstep[0]) begin
            first_d = prod_q;
          end else begin
            mag_d[kstep[2:1]] = cmag[65:0];
            neg_d[kstep[2:1]] = cdiff[66];
          end
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'd6) begin
          state_d = fng_pkg::ST_NORM;
        end
      end
      fng_pkg::ST_NORM: begin
        if (orv == '0) begin
          nrm_d[0] = '0;
          nrm_d[1] = '0;
          nrm_d[2] = '0;
          degen_d  = 1'b1;
          state_d  = fng_pkg::ST_EMIT;
        end else if (orv[65:fng_pkg::NORM_BITS] != '0) begin
          // truncate all magnitudes together until the largest fits
          mag_d[0] = mag_q[0] >> 1;
          mag_d[1] = mag_q[1] >> 1;
          mag_d[2] = mag_q[2] >> 1;
        end else begin
          step_d  = '0;
          state_d = fng_pkg::ST_SQUARE;
        end
      end
      fng_pkg::ST_SQUARE: begin
        if (step_q < 3'd3) begin
          mul_a  = signed'({3'b000, mag_q[step_q[1:0]][29:0]});
          mul_b  = signed'({3'b000, mag_q[step_q[1:0]][29:0]});
          prod_d = mul_prod;
        end
        if (step_q == 3'd0) begin
          sum_d = '0;
        end else begin
          sum_d = sum_q + prod_q[61:0];
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'd3) begin
          state_d = fng_pkg::ST_SQRT_GO;
        end
      end
      fng_pkg::ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_d    = fng_pkg::ST_SQRT;
      end
      fng_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          len_d   = sqrt_root;
          comp_d  = '0;
          state_d = fng_pkg::ST_DLOAD;
        end
      end
      fng_pkg::ST_DLOAD: begin
        // numerator c * 32768 + len rounds half away from zero
        rem_d   = 48'({mag_q[comp_q][29:0], 15'b0}) + 48'(len_q);
        quo_d   = '0;
        cnt_d   = 4'd15;
        state_d = fng_pkg::ST_DIV;
      end
      fng_pkg::ST_DIV: begin
        if (hit) begin
          rem_d = rem_q - trial;
        end
        quo_d = quo_set;
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          nrm_d[comp_q] = neg_q[comp_q] ? signed'(16'd0 - qclamp) : signed'(qclamp);
          if (comp_q == 2'd2) begin
            state_d = fng_pkg::ST_EMIT;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = fng_pkg::ST_DLOAD;
          end
        end
      end
      fng_pkg::ST_EMIT: begin
        if (normal_o.ready) begin
          left_d = left_q - 3'd1;
          if (left_q == 3'd1) begin
            state_d = fng_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = fng_pkg::ST_IDLE;
      end
    endcase

    // a mode write drops any partial group
    if (cfg_we_i) begin
      mode_d = cfg_wdata_i;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fng_pkg::ST_IDLE;
      mode_q  <= 1'b0;
      pos_q   <= '0;
      step_q  <= '0;
      left_q  <= '0;
      comp_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      step_q  <= step_d;
      left_q  <= left_d;
      comp_q  <= comp_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_x_q[pos_q] <= vertex_i.vertex_x;
      held_y_q[pos_q] <= vertex_i.vertex_y;
      held_z_q[pos_q] <= vertex_i.vertex_z;
    end
    diff_q  <= diff_d;
    prod_q  <= prod_d;
    first_q <= first_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    sum_q   <= sum_d;
    len_q   <= len_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    nrm_q   <= nrm_d;
    degen_q <= degen_d;
  end

`ifndef SYNTH
  // never take a vertex while normals are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(normal_o.valid && vertex_i.ready))
    else $error("vertex accepted while normals pending");

  // a degenerate normal is exactly zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (normal_o.valid && normal_o.degenerate) |->
      (normal_o.normal_x == 16'sd0 && normal_o.normal_y == 16'sd0 &&
       normal_o.normal_z == 16'sd0))
    else $error("degenerate normal not zero");

  // a triangle group never holds three vertices at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fng_pkg::ST_IDLE && !mode_q) |-> (pos_q != 2'd3))
    else $error("triangle group overran");

  // the last transaction of a run ends the emit phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (normal_o.valid && normal_o.ready && normal_o.last_of_run) |=>
      (state_q == fng_pkg::ST_IDLE))
    else $error("emit phase did not end after last normal");
`endif

endmodule
`default_nettype wire

FILE: dv/tb.sv
// testbench of face_normal_generator_top: directed and random vertex streams checked per normal
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               eob;
  } vertex_t;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degenerate;
    logic               last_of_run;
  } normal_t;

  // cycles a closing vertex may take
  localparam int SETTLE_CYCLES = 150;
  localparam int STALL_LIMIT   = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  fng_vertex_if vtx ();
  fng_normal_if nrm ();

  face_normal_generator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vertex_i    (vtx),
    .normal_o    (nrm),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: own copy of mode, held vertices and group position
  logic    quad_mode;
  vertex_t held_vtx [3];
  int      group_pos;
  normal_t normal_queue [$];
  int      fail_count;
  bit      no_idle;
  int      quiet_cycles;
  int      ready_hold = 0;

  initial begin
    vtx.valid         = 1'b0;
    vtx.vertex_x      = '0;
    vtx.vertex_y      = '0;
    vtx.vertex_z      = '0;
    vtx.end_of_buffer = 1'b0;
    nrm.ready         = 1'b0;
  end

  // gap length: mostly none or short, a few long; none at all in burst stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // unit face normal of the held triangle in Q2.14, exact cross product
  function automatic normal_t face_normal();
    normal_t            n;
    logic signed [67:0] ea [3];
    logic signed [67:0] eb [3];
    logic signed [67:0] cr [3];
    logic        [67:0] mg [3];
    longint unsigned    m [3];
    longint unsigned    sum, len, q;
    logic signed [15:0] comp [3];
    int                 blen, s;
    ea[0] = longint'(held_vtx[1].x) - longint'(held_vtx[0].x);
    ea[1] = longint'(held_vtx[1].y) - longint'(held_vtx[0].y);
    ea[2] = longint'(held_vtx[1].z) - longint'(held_vtx[0].z);
    eb[0] = longint'(held_vtx[1].x) - longint'(held_vtx[2].x);
    eb[1] = longint'(held_vtx[1].y) - longint'(held_vtx[2].y);
    eb[2] = longint'(held_vtx[1].z) - longint'(held_vtx[2].z);
    cr[0] = ea[2] * eb[1] - ea[1] * eb[2];
    cr[1] = ea[0] * eb[2] - ea[2] * eb[0];
    cr[2] = ea[1] * eb[0] - ea[0] * eb[1];
    blen = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
      for (int k = 67; k >= 0; k--)
        if (mg[i][k]) begin
          if (k + 1 > blen) blen = k + 1;
          break;
        end
    end
    n.last_of_run = 1'b0;
    if (blen == 0) begin
      n.nx = '0; n.ny = '0; n.nz = '0;
      n.degenerate = 1'b1;
      return n;
    end
    s = blen > fng_pkg::NORM_BITS ? blen - fng_pkg::NORM_BITS : 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = 64'(mg[i] >> s);
      sum += m[i] * m[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 32768 + len) / (2 * len);
      if (q > 16384) q = 16384;
      comp[i] = cr[i] < 0 ? -16'(q) : 16'(q);
    end
    n.nx = comp[0]; n.ny = comp[1]; n.nz = comp[2];
    n.degenerate = 1'b0;
    return n;
  endfunction

  // advance the predictor by one accepted vertex, queue the normals it causes
  task automatic predict_vertex(vertex_t v);
    int      size, count;
    normal_t n;
    size = quad_mode ? 4 : 3;
    if (group_pos < 3) held_vtx[group_pos] = v;
    group_pos++;
    if (group_pos >= size) begin
      count = size;
      n = face_normal();
    end else if (v.eob) begin
      count = group_pos;
      n = '{nx: '0, ny: '0, nz: '0, degenerate: 1'b1, last_of_run: 1'b0};
    end else begin
      return;
    end
    group_pos = 0;
    for (int k = 0; k < count; k++) begin
      n.last_of_run = (k == count - 1);
      normal_queue.push_back(n);
    end
  endtask

  // one vertex transaction; entered and left at a falling edge
  task automatic send_vertex(vertex_t v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      vtx.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    vtx.valid         <= 1'b1;
    vtx.vertex_x      <= v.x;
    vtx.vertex_y      <= v.y;
    vtx.vertex_z      <= v.z;
    vtx.end_of_buffer <= v.eob;
    do @(posedge clk_i); while (!vtx.ready);
    predict_vertex(v);
    @(negedge clk_i);
  endtask

  task automatic send_xyz(int x, int y, int z, bit eob);
    vertex_t v;
    v = '{x: x, y: y, z: z, eob: eob};
    send_vertex(v);
  endtask

  // drain all pending normals, let the sequencer settle, then write the mode
  task automatic write_mode(logic mode);
    vtx.valid <= 1'b0;
    @(negedge clk_i);
    while (normal_queue.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    quad_mode = mode;
    group_pos = 0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2, 3: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      4: begin
        case ($urandom_range(0, 2))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          default: return 32'sh0;
        endcase
      end
      default: return $signed($urandom_range(0, 64)) - 32;
    endcase
  endfunction

  function automatic vertex_t rand_vertex(bit eob);
    vertex_t v;
    v.x = rand_coord();
    v.y = rand_coord();
    v.z = rand_coord();
    v.eob = eob;
    return v;
  endfunction

  // random normal-side backpressure: mostly short gaps, a few long stalls
  always @(negedge clk_i) begin
    if (!rst_ni) nrm.ready <= 1'b0;
    else if (no_idle) nrm.ready <= 1'b1;
    else if (ready_hold > 0) begin
      nrm.ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 99) < 3) begin
      nrm.ready  <= 1'b0;
      ready_hold <= $urandom_range(10, 40);
    end else nrm.ready <= ($urandom_range(0, 99) < 70);
  end

  // compare each accepted normal with the oldest expected one
  always @(posedge clk_i) begin
    normal_t exp_n;
    if (rst_ni && nrm.valid && nrm.ready) begin
      if (normal_queue.size() == 0) begin
        $error("unexpected normal x=%0d y=%0d z=%0d", nrm.normal_x, nrm.normal_y,
               nrm.normal_z);
        fail_count++;
      end else begin
        exp_n = normal_queue.pop_front();
        if (nrm.normal_x !== exp_n.nx) begin
          $error("normal_x expected %0d actual %0d", exp_n.nx, nrm.normal_x);
          fail_count++;
        end
        if (nrm.normal_y !== exp_n.ny) begin
          $error("normal_y expected %0d actual %0d", exp_n.ny, nrm.normal_y);
          fail_count++;
        end
        if (nrm.normal_z !== exp_n.nz) begin
          $error("normal_z expected %0d actual %0d", exp_n.nz, nrm.normal_z);
          fail_count++;
        end
        if (nrm.degenerate !== exp_n.degenerate) begin
          $error("degenerate expected %0b actual %0b", exp_n.degenerate, nrm.degenerate);
          fail_count++;
        end
        if (nrm.last_of_run !== exp_n.last_of_run) begin
          $error("last_of_run expected %0b actual %0b", exp_n.last_of_run,
                 nrm.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if ((vtx.valid && vtx.ready) || (nrm.valid && nrm.ready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // simple triangles in triangle mode, ending mid-group before the next mode write
  task automatic test_directed_triangles();
    write_mode(1'b0);
    // xy plane triangle: normal along z
    send_xyz(0, 0, 0, 0);
    send_xyz(32'sh0001_0000, 0, 0, 0);
    send_xyz(0, 32'sh0001_0000, 0, 0);
    // collinear vertices give a degenerate face
    send_xyz(0, 0, 0, 0);
    send_xyz(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 0);
    send_xyz(32'sh0004_0000, 32'sh0004_0000, 32'sh0004_0000, 0);
    // extreme coordinates, widest edges
    send_xyz(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 0);
    send_xyz(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_xyz(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    // group completed on a vertex that also carries end of buffer
    send_xyz(0, 0, 32'sh0001_0000, 0);
    send_xyz(-1, 5, 7, 0);
    send_xyz(32'sh7fff_ffff, -3, 1, 1);
    // partial flushes of one and two vertices
    send_xyz(1, 2, 3, 1);
    send_xyz(4, 5, 6, 0);
    send_xyz(7, 8, 9, 1);
    // two vertices then a mode write discards them
    send_xyz(11, 12, 13, 0);
    send_xyz(14, 15, 16, 0);
  endtask

  task automatic test_directed_quads();
    write_mode(1'b1);
    send_xyz(0, 0, 0, 0);
    send_xyz(0, 32'sh0001_0000, 0, 0);
    send_xyz(0, 0, 32'sh0001_0000, 0);
    send_xyz(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
    // three vertices flushed by end of buffer
    send_xyz(1, 0, 0, 0);
    send_xyz(0, 1, 0, 0);
    send_xyz(0, 0, 1, 1);
    // quad closed on its fourth vertex, which also carries end of buffer
    send_xyz(-5, 9, 2, 0);
    send_xyz(3, -8, 6, 0);
    send_xyz(32'sh8000_0000, 1, -1, 0);
    send_xyz(0, 0, 0, 1);
    send_xyz(2, 2, 2, 0);
  endtask

  // mostly whole groups with random content, some early flushes
  task automatic test_random_groups(logic mode, int n_items, bit burst);
    int size, pos, sent;
    bit eob;
    write_mode(mode);
    no_idle = burst;
    size = mode ? 4 : 3;
    pos = 0;
    sent = 0;
    while (sent < n_items) begin
      pos++;
      eob = ($urandom_range(0, 99) < 12);
      send_vertex(rand_vertex(eob));
      sent++;
      if (eob || pos == size) pos = 0;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    fail_count = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    quad_mode = 1'b0;
    group_pos = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_triangles();
    test_directed_quads();
    test_random_groups(1'b0, 75, 1'b0);
    test_random_groups(1'b1, 65, 1'b0);
    test_random_groups(1'b0, 40, 1'b1);
    test_random_groups(1'b1, 40, 1'b1);
    test_random_groups(1'b0, 50, 1'b0);
    test_random_groups(1'b1, 30, 1'b0);

    vtx.valid <= 1'b0;
    while (normal_queue.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && normal_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
